/* hdl/gbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_pkg: shared types for the graph traversal core
// Item layouts, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam int unsigned VTX_W = 6;
  localparam int unsigned CNT_W = 7;
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_BFS   = 2'd2,
    OP_DFS   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_E_WA,
    ST_E_RB,
    ST_E_WB,
    ST_Q_RD,
    ST_Q_ROW,
    ST_Q_CAND,
    ST_Q_PUSH,
    ST_D_EVAL,
    ST_D_TOP,
    ST_FLUSH
  } st_e;

  typedef struct packed {
    op_e              op;
    logic [VTX_W-1:0] edge_from;
    logic [VTX_W-1:0] edge_to;
    logic [VTX_W-1:0] start_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] vertex_count;
  } cfg_item_t;

endpackage

/* hdl/gbt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbt_if: valid/ready channels of the graph traversal core
// Command, result and configuration channels, each with source and sink views.
// ----------------------------------------------------------------------------
interface gbt_in_if;
  logic              valid;
  logic              ready;
  gbt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gbt_out_if;
  logic               valid;
  logic               ready;
  gbt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gbt_cfg_if;
  logic               valid;
  logic               ready;
  gbt_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/graph_bfs_dfs_traversal_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_core: adjacency-matrix graph with BFS / DFS walks
// Holds the graph as bit rows in a synchronous RAM, the walk queue/stack in a
// second RAM, and streams visited vertices with the final one flagged.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  in_i     in   op, edge_from, edge_to, start_vertex      valid/ready
//  out_o    out  vertex, last                              valid/ready
//  cfg_i    in   vertex_count                              valid/ready
//
//  Clear drops the row valid flags at once; add edge is a read-modify-write
//  of both rows in the single adjacency RAM (read and write A, then B).
//  BFS: each dequeued vertex needs the queue RAM read, then its adjacency row
//  read and a candidate step, and each new neighbour is then queued. DFS: a
//  descent reads one row, a backtrack the stack RAM then the row; a flush ends it.
//  A result waits in a one-deep hold stage until the next one or the end of
//  the walk marks it; a full output register stalls the sequencer.
//  Reset leaves the graph empty and vertex_count at 64; no RAM sweep needed.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal_core #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gbt_in_if.sink      in_i,
  gbt_out_if.source   out_o,
  gbt_cfg_if.sink     cfg_i
);
  import gbt_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  st_e                     state_q, state_d;
  logic [CNT_W-1:0]        cnt_q;
  logic [CNT_W-1:0]        n_eff;
  logic [MAX_VERTICES-1:0] col_mask;

  // adjacency RAM
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q, row_vld_d;
  logic                    adj_re, adj_we;
  logic [AW-1:0]           adj_raddr, adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata_q, adj_row;
  logic                    adj_rvld_q;

  // queue / stack RAM
  logic [AW-1:0]           pend_mem [MAX_VERTICES];
  logic                    pend_re, pend_we;
  logic [AW-1:0]           pend_raddr, pend_waddr, pend_wdata, pend_rdata_q;

  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [MAX_VERTICES-1:0] cand_q, cand_d, cand_now, enc_src, low_onehot;
  logic [AW-1:0]           low_idx;
  logic [CW-1:0]           head_q, head_d, tail_q, tail_d;
  logic [AW-1:0]           ea_q, ea_d, eb_q, eb_d;
  logic                    hold_vld_q, hold_vld_d;
  logic [AW-1:0]           hold_vtx_q, hold_vtx_d;
  logic                    out_vld_q, out_vld_d, out_last_q, out_last_d;
  logic [VTX_W-1:0]        out_vtx_q, out_vtx_d;
  logic                    out_free, can_emit, a_ok, b_ok, s_ok;

  assign n_eff = (cnt_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : cnt_q;

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      col_mask[j] = (CNT_W'(j) < n_eff);
    end
  end

  assign a_ok = (CNT_W'(in_i.data.edge_from) < n_eff);
  assign b_ok = (CNT_W'(in_i.data.edge_to) < n_eff);
  assign s_ok = (CNT_W'(in_i.data.start_vertex) < n_eff);

  // a row never written since the last clear reads as empty
  assign adj_row  = adj_rvld_q ? adj_rdata_q : '0;
  assign cand_now = adj_row & ~visited_q & col_mask;

  // lowest set bit, then its index
  assign enc_src    = (state_q == ST_D_EVAL) ? cand_now : cand_q;
  assign low_onehot = enc_src & (~enc_src + MAX_VERTICES'(1));

  always_comb begin
    low_idx = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (low_onehot[j]) low_idx = low_idx | AW'(j);
    end
  end

  assign out_free = !out_vld_q || out_o.ready;
  assign can_emit = !hold_vld_q || out_free;

  assign in_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_vld_q;
  assign out_o.data.vertex = out_vtx_q;
  assign out_o.data.last   = out_last_q;

  always_comb begin
    state_d    = state_q;
    row_vld_d  = row_vld_q;
    visited_d  = visited_q;
    cand_d     = cand_q;
    head_d     = head_q;
    tail_d     = tail_q;
    ea_d       = ea_q;
    eb_d       = eb_q;
    hold_vld_d = hold_vld_q;
    hold_vtx_d = hold_vtx_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_vtx_d  = out_vtx_q;
    out_last_d = out_last_q;
    adj_re     = 1'b0;
    adj_raddr  = '0;
    adj_we     = 1'b0;
    adj_waddr  = '0;
    adj_wdata  = '0;
    pend_re    = 1'b0;
    pend_raddr = '0;
    pend_we    = 1'b0;
    pend_waddr = '0;
    pend_wdata = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          unique case (in_i.data.op)
            OP_CLEAR: row_vld_d = '0;
            OP_EDGE: begin
              if (a_ok && b_ok) begin
                ea_d      = in_i.data.edge_from[AW-1:0];
                eb_d      = in_i.data.edge_to[AW-1:0];
                adj_re    = 1'b1;
                adj_raddr = in_i.data.edge_from[AW-1:0];
                state_d   = ST_E_WA;
              end
            end
            OP_BFS: begin
              if (s_ok) begin
                visited_d  = MAX_VERTICES'(1) << in_i.data.start_vertex[AW-1:0];
                head_d     = '0;
                tail_d     = CW'(1);
                pend_we    = 1'b1;
                pend_waddr = '0;
                pend_wdata = in_i.data.start_vertex[AW-1:0];
                state_d    = ST_Q_RD;
              end
            end
            OP_DFS: begin
              if (s_ok) begin
                visited_d  = MAX_VERTICES'(1) << in_i.data.start_vertex[AW-1:0];
                tail_d     = CW'(1);
                pend_we    = 1'b1;
                pend_waddr = '0;
                pend_wdata = in_i.data.start_vertex[AW-1:0];
                hold_vld_d = 1'b1;
                hold_vtx_d = in_i.data.start_vertex[AW-1:0];
                adj_re     = 1'b1;
                adj_raddr  = in_i.data.start_vertex[AW-1:0];
                state_d    = ST_D_EVAL;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_E_WA: begin
        adj_we        = 1'b1;
        adj_waddr     = ea_q;
        adj_wdata     = adj_row | (MAX_VERTICES'(1) << eb_q);
        row_vld_d[ea_q] = 1'b1;
        state_d       = ST_E_RB;
      end

      // second row is read only after the first write has landed (self loops)
      ST_E_RB: begin
        adj_re    = 1'b1;
        adj_raddr = eb_q;
        state_d   = ST_E_WB;
      end

      ST_E_WB: begin
        adj_we        = 1'b1;
        adj_waddr     = eb_q;
        adj_wdata     = adj_row | (MAX_VERTICES'(1) << ea_q);
        row_vld_d[eb_q] = 1'b1;
        state_d       = ST_IDLE;
      end

      ST_Q_RD: begin
        pend_re    = 1'b1;
        pend_raddr = head_q[AW-1:0];
        state_d    = ST_Q_ROW;
      end

      ST_Q_ROW: begin
        if (can_emit) begin
          if (hold_vld_q) begin
            out_vld_d  = 1'b1;
            out_vtx_d  = VTX_W'(hold_vtx_q);
            out_last_d = 1'b0;
          end
          hold_vld_d = 1'b1;
          hold_vtx_d = pend_rdata_q;
          adj_re     = 1'b1;
          adj_raddr  = pend_rdata_q;
          head_d     = head_q + CW'(1);
          state_d    = ST_Q_CAND;
        end
      end

      // all new neighbours are marked at once; they are queued one a cycle
      ST_Q_CAND: begin
        cand_d    = cand_now;
        visited_d = visited_q | cand_now;
        state_d   = ST_Q_PUSH;
      end

      ST_Q_PUSH: begin
        if (cand_q != '0) begin
          pend_we    = 1'b1;
          pend_waddr = tail_q[AW-1:0];
          pend_wdata = low_idx;
          tail_d     = tail_q + CW'(1);
          cand_d     = cand_q & ~low_onehot;
        end else if (head_q == tail_q) begin
          state_d = ST_FLUSH;
        end else begin
          pend_re    = 1'b1;
          pend_raddr = head_q[AW-1:0];
          state_d    = ST_Q_ROW;
        end
      end

      ST_D_EVAL: begin
        if (cand_now != '0) begin
          if (can_emit) begin
            if (hold_vld_q) begin
              out_vld_d  = 1'b1;
              out_vtx_d  = VTX_W'(hold_vtx_q);
              out_last_d = 1'b0;
            end
            hold_vld_d = 1'b1;
            hold_vtx_d = low_idx;
            pend_we    = 1'b1;
            pend_waddr = tail_q[AW-1:0];
            pend_wdata = low_idx;
            tail_d     = tail_q + CW'(1);
            visited_d  = visited_q | low_onehot;
            adj_re     = 1'b1;
            adj_raddr  = low_idx;
          end
        end else begin
          tail_d = tail_q - CW'(1);
          if (tail_q == CW'(1)) begin
            state_d = ST_FLUSH;
          end else begin
            // fetch the new top of stack
            pend_re    = 1'b1;
            pend_raddr = AW'(tail_q - CW'(2));
            state_d    = ST_D_TOP;
          end
        end
      end

      ST_D_TOP: begin
        adj_re    = 1'b1;
        adj_raddr = pend_rdata_q;
        state_d   = ST_D_EVAL;
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_vtx_d  = VTX_W'(hold_vtx_q);
          out_last_d = 1'b1;
          hold_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= CNT_RESET;
      row_vld_q  <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_vld_q  <= row_vld_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_i.valid && cfg_i.ready) begin
        cnt_q <= cfg_i.data.vertex_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    visited_q  <= visited_d;
    cand_q     <= cand_d;
    ea_q       <= ea_d;
    eb_q       <= eb_d;
    hold_vtx_q <= hold_vtx_d;
    out_vtx_q  <= out_vtx_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rdata_q <= adj_mem[adj_raddr];
      adj_rvld_q  <= row_vld_q[adj_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    if (pend_re) begin
      pend_rdata_q <= pend_mem[pend_raddr];
    end
  end

`ifndef SYNTHESIS
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= CW'(MAX_VERTICES))
    else $error("stack/queue depth beyond vertex capacity");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_RD || state_q == ST_Q_ROW || state_q == ST_Q_CAND ||
     state_q == ST_Q_PUSH) |-> head_q <= tail_q)
    else $error("queue head passed tail");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !hold_vld_q)
    else $error("walk ended with an unflushed item");

  a_clear_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.data.op == OP_CLEAR) |=> row_vld_q == '0)
    else $error("clear left rows valid");
`endif

endmodule
